// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the plant emulator RTL. Each macro wraps one
// clocked concurrent assertion that is disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- design/fopdt_pkg.sv -----
// ----------------------------------------------------------------------------
// fopdt_pkg
// Shared types, constants and fixed-point helpers for the first-order plant
// with dead time emulator.
// ----------------------------------------------------------------------------
package fopdt_pkg;

  // Field widths.
  localparam int DRIVE_W    = 32;
  localparam int GAIN_W     = 24;
  localparam int HALF_W     = 16;
  localparam int DLEN_W     = 9;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = 58;
  localparam int RND_W      = PROD_W - 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_OVER_TAU = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TAU       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 8'd3;

  // Configuration reset values.
  localparam logic [GAIN_W-1:0] RST_GAIN_OVER_TAU = 24'd16384;
  localparam logic [GAIN_W-1:0] RST_INV_TAU       = 24'd16384;
  localparam logic [HALF_W-1:0] RST_HALF_STEP     = 16'd328;
  localparam logic [DLEN_W-1:0] RST_DELAY_LENGTH  = 9'd0;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULG,
    ST_MULI,
    ST_DERIV,
    ST_MULH,
    ST_COMMIT
  } fopdt_state_t;

  // Operand pair for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_GAIN,
    MUL_ITAU,
    MUL_HALF
  } fopdt_mulop_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         accept;
    logic         mul_en;
    fopdt_mulop_t mul_op;
    logic         acc_ld;
    logic         deriv_ld;
    logic         commit;
  } fopdt_cmd_t;

  // Q.32 product to Q16.16: add one half LSB, then floor.
  function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = v + 58'sd32768;
    return t[PROD_W-1:16];
  endfunction

  // Saturate to signed 32 bits.
  function automatic logic signed [DRIVE_W-1:0] sat32(input logic signed [RND_W-1:0] v);
    if (v[RND_W-1:DRIVE_W-1] == {(RND_W-DRIVE_W+1){v[RND_W-1]}}) begin
      return v[DRIVE_W-1:0];
    end else if (v[RND_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

endpackage

// ----- design/fopdt_in_if.sv -----
// ----------------------------------------------------------------------------
// fopdt_in_if
// Drive sample channel: one item per plant tick.
// ----------------------------------------------------------------------------
interface fopdt_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [fopdt_pkg::DRIVE_W-1:0]       drive_in;

  modport source (output valid, output drive_in, input ready);
  modport sink   (input valid, input drive_in, output ready);
endinterface

// ----- design/fopdt_out_if.sv -----
// ----------------------------------------------------------------------------
// fopdt_out_if
// Plant output channel: undelayed and delayed output of one tick.
// ----------------------------------------------------------------------------
interface fopdt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fopdt_pkg::DRIVE_W-1:0] plant_out;
  logic signed [fopdt_pkg::DRIVE_W-1:0] delayed_out;

  modport source (output valid, output plant_out, output delayed_out, input ready);
  modport sink   (input valid, input plant_out, input delayed_out, output ready);
endinterface

// ----- design/fopdt_cfg_if.sv -----
// ----------------------------------------------------------------------------
// fopdt_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fopdt_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fopdt_pkg::CFG_IDX_W-1:0]     index;
  logic [fopdt_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/fopdt_ram.sv -----
// ----------------------------------------------------------------------------
// fopdt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fopdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/fopdt_ctrl.sv -----
// ----------------------------------------------------------------------------
// fopdt_ctrl
// Sequencing controller: walks one item through the three multiplies, the
// derivative update and the commit, and owns the channel handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fopdt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fopdt_pkg::fopdt_cmd_t cmd
);

  fopdt_pkg::fopdt_state_t state_r, state_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    slot_free;

  // The output register can take a new item when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fopdt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = fopdt_pkg::ST_MULG;
        end
      end
      fopdt_pkg::ST_MULG:  state_nxt = fopdt_pkg::ST_MULI;
      fopdt_pkg::ST_MULI:  state_nxt = fopdt_pkg::ST_DERIV;
      fopdt_pkg::ST_DERIV: state_nxt = fopdt_pkg::ST_MULH;
      fopdt_pkg::ST_MULH:  state_nxt = fopdt_pkg::ST_COMMIT;
      fopdt_pkg::ST_COMMIT: begin
        if (slot_free) begin
          state_nxt = fopdt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fopdt_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mul_op   = fopdt_pkg::MUL_GAIN;
    unique case (state_r)
      fopdt_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      fopdt_pkg::ST_MULG: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = fopdt_pkg::MUL_GAIN;
      end
      fopdt_pkg::ST_MULI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = fopdt_pkg::MUL_ITAU;
        cmd.acc_ld = 1'b1;
      end
      fopdt_pkg::ST_DERIV: begin
        cmd.deriv_ld = 1'b1;
      end
      fopdt_pkg::ST_MULH: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = fopdt_pkg::MUL_HALF;
      end
      fopdt_pkg::ST_COMMIT: begin
        cmd.commit = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Output valid flag: set by a commit, cleared when the item is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fopdt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A commit must never overwrite a result that is still waiting.
  `ASSERT_IMPL(a_commit_free, clk, rst_n, cmd.commit, (!out_valid_r || out_ready), "commit while output busy")
  // An accepted item always starts with the gain multiply.
  `ASSERT_NEXT(a_accept_start, clk, rst_n, cmd.accept, (state_r == fopdt_pkg::ST_MULG), "accept did not start sequence")
  // A result only appears after a commit.
  `ASSERT_IMPL(a_out_rise, clk, rst_n, $rose(out_valid_r), $past(cmd.commit), "output valid without commit")

endmodule

// ----- design/fopdt_dp.sv -----
// ----------------------------------------------------------------------------
// fopdt_dp
// Datapath: configuration registers, shared multiplier, rounding and
// saturation, plant state and the ring delay line with its fill count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fopdt_dp #(
  parameter int DELAY_DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fopdt_pkg::fopdt_cmd_t                 cmd,
  input  logic                                  cfg_we,
  input  logic [fopdt_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [fopdt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [fopdt_pkg::DRIVE_W-1:0]  drive_in,
  output logic signed [fopdt_pkg::DRIVE_W-1:0]  plant_out,
  output logic signed [fopdt_pkg::DRIVE_W-1:0]  delayed_out
);

  localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int CW = $clog2(DELAY_DEPTH + 1);
  localparam int LW = (CW > fopdt_pkg::DLEN_W) ? CW : fopdt_pkg::DLEN_W;
  localparam int PW = fopdt_pkg::PROD_W;
  localparam int RW = fopdt_pkg::RND_W;
  localparam int DW = fopdt_pkg::DRIVE_W;

  // Configuration registers.
  logic [fopdt_pkg::GAIN_W-1:0] gain_r, gain_nxt;
  logic [fopdt_pkg::GAIN_W-1:0] itau_r, itau_nxt;
  logic [fopdt_pkg::HALF_W-1:0] half_r, half_nxt;
  logic [fopdt_pkg::DLEN_W-1:0] dlen_r, dlen_nxt;

  // Plant state.
  logic signed [DW-1:0] y_r, d_r, yd_r;
  logic signed [DW-1:0] y_nxt, yd_nxt;

  // Per-item working registers.
  logic signed [DW-1:0] u_r, dnew_r;
  logic signed [PW-1:0] prod_r, acc_r;
  logic                 hit_r, len_zero_r;
  logic signed [DW-1:0] plant_out_r, delayed_out_r;

  // Ring pointer and fill count.
  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] fill_r, fill_nxt;

  // Multiplier and read address.
  logic signed [32:0]   mul_a;
  logic signed [24:0]   mul_b;
  logic signed [PW-1:0] prod;
  logic [LW-1:0]        len_ext;
  logic [CW-1:0]        len_sat;
  logic [CW:0]          rd_sum, rd_wrap;
  logic [AW-1:0]        rd_addr;
  logic                 rd_hit;
  logic [DW-1:0]        ram_rdata;
  logic signed [RW-1:0] y_sum;

  // Register writes.
  always_comb begin
    gain_nxt = gain_r;
    itau_nxt = itau_r;
    half_nxt = half_r;
    dlen_nxt = dlen_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        fopdt_pkg::REG_GAIN_OVER_TAU: gain_nxt = cfg_data[fopdt_pkg::GAIN_W-1:0];
        fopdt_pkg::REG_INV_TAU:       itau_nxt = cfg_data[fopdt_pkg::GAIN_W-1:0];
        fopdt_pkg::REG_HALF_STEP:     half_nxt = cfg_data[fopdt_pkg::HALF_W-1:0];
        fopdt_pkg::REG_DELAY_LENGTH:  dlen_nxt = cfg_data[fopdt_pkg::DLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    unique case (cmd.mul_op)
      fopdt_pkg::MUL_GAIN: begin
        mul_a = 33'(u_r);
        mul_b = {1'b0, gain_r};
      end
      fopdt_pkg::MUL_ITAU: begin
        mul_a = 33'(yd_r);
        mul_b = {1'b0, itau_r};
      end
      fopdt_pkg::MUL_HALF: begin
        mul_a = 33'(dnew_r) + 33'(d_r);
        mul_b = {9'd0, half_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Delay read slot: (wp - length) mod depth, length clamped to the depth.
  assign len_ext = LW'(dlen_r);
  assign len_sat = (len_ext > LW'(DELAY_DEPTH)) ? CW'(DELAY_DEPTH) : CW'(len_ext);
  assign rd_sum  = (CW+1)'(wp_r) + (CW+1)'(DELAY_DEPTH) - (CW+1)'(len_sat);
  assign rd_wrap = (rd_sum >= (CW+1)'(DELAY_DEPTH)) ? rd_sum - (CW+1)'(DELAY_DEPTH) : rd_sum;
  assign rd_addr = AW'(rd_wrap);
  // Slots fill in order from zero, so a slot below the fill count holds data.
  assign rd_hit  = (fill_r == CW'(DELAY_DEPTH)) || (rd_wrap < (CW+1)'(fill_r));

  // Trapezoid sum and delayed output selection at commit.
  assign y_sum  = RW'(y_r) + fopdt_pkg::round_q16(prod_r);
  assign y_nxt  = fopdt_pkg::sat32(y_sum);
  assign yd_nxt = len_zero_r ? y_nxt : (hit_r ? $signed(ram_rdata) : '0);

  // Ring pointer and fill count advance.
  assign wp_nxt   = (wp_r == AW'(DELAY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
  assign fill_nxt = (fill_r == CW'(DELAY_DEPTH)) ? fill_r : fill_r + CW'(1);

  fopdt_ram #(
    .WIDTH (DW),
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_delay_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (wp_r),
    .wdata (y_nxt),
    .re    (cmd.accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Control and plant state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= fopdt_pkg::RST_GAIN_OVER_TAU;
      itau_r <= fopdt_pkg::RST_INV_TAU;
      half_r <= fopdt_pkg::RST_HALF_STEP;
      dlen_r <= fopdt_pkg::RST_DELAY_LENGTH;
      y_r    <= '0;
      d_r    <= '0;
      yd_r   <= '0;
      wp_r   <= '0;
      fill_r <= '0;
    end else begin
      gain_r <= gain_nxt;
      itau_r <= itau_nxt;
      half_r <= half_nxt;
      dlen_r <= dlen_nxt;
      if (cmd.commit) begin
        y_r    <= y_nxt;
        d_r    <= dnew_r;
        yd_r   <= yd_nxt;
        wp_r   <= wp_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      u_r        <= drive_in;
      hit_r      <= rd_hit;
      len_zero_r <= (len_sat == '0);
    end
    if (cmd.mul_en) begin
      prod_r <= prod;
    end
    if (cmd.acc_ld) begin
      acc_r <= prod_r;
    end
    if (cmd.deriv_ld) begin
      dnew_r <= fopdt_pkg::sat32(fopdt_pkg::round_q16(acc_r - prod_r));
    end
    if (cmd.commit) begin
      plant_out_r   <= y_nxt;
      delayed_out_r <= yd_nxt;
    end
  end

  assign plant_out   = plant_out_r;
  assign delayed_out = delayed_out_r;

  // The fill count saturates at the depth.
  `ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, (fill_r <= CW'(DELAY_DEPTH)), "fill count beyond depth")
  // Until the ring has wrapped, the write pointer tracks the fill count.
  `ASSERT_IMPL(a_fill_wp, clk, rst_n, (fill_r != CW'(DELAY_DEPTH)), ((CW+1)'(wp_r) == (CW+1)'(fill_r)), "pointer and fill count disagree")
  // With no dead time, both outputs of a tick are equal.
  `ASSERT_NEXT(a_zero_len, clk, rst_n, (cmd.commit && len_zero_r), (delayed_out_r == plant_out_r), "zero delay output mismatch")

endmodule

// ----- design/first_order_plant_with_dead_time_unit.sv -----
// ----------------------------------------------------------------------------
// first_order_plant_with_dead_time_unit
// First-order plant with dead time, trapezoidal integration in Q16.16.
//
//   Port      Dir  Contents
//   in_chan   in   drive_in (signed Q16.16), one item per tick
//   out_chan  out  plant_out, delayed_out (signed Q16.16)
//   cfg_chan  in   index 0..3, data (gain_over_tau, inv_tau, half_step,
//                  delay_length)
//
// Each item walks the gain, inv-tau, derivative, half-step and commit states;
// the next item is accepted after the commit. The sequence is set by the one
// shared multiplier, used three times per item, and the rounding between.
// The delay line is a RAM tracked by a fill count, so no clearing pass runs
// after reset. A stalled output holds the result; the next item is still
// taken, and its commit waits until the output register is free.
// ----------------------------------------------------------------------------
module first_order_plant_with_dead_time_unit #(
  parameter int DELAY_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  fopdt_in_if.sink    in_chan,
  fopdt_out_if.source out_chan,
  fopdt_cfg_if.sink   cfg_chan
);

  fopdt_pkg::fopdt_cmd_t cmd;
  logic                  in_ready;
  logic                  out_valid;

  // The register file takes a write in any cycle.
  assign cfg_chan.ready = 1'b1;

  fopdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  fopdt_dp #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_we      (cfg_chan.valid),
    .cfg_idx     (cfg_chan.index),
    .cfg_data    (cfg_chan.data),
    .drive_in    (in_chan.drive_in),
    .plant_out   (out_chan.plant_out),
    .delayed_out (out_chan.delayed_out)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule
